@@ design/slr_pkg.sv @@
// ----------------------------------------------------------------------------
// slr_pkg - shared types and constants of the segmented lane reducer
// Request structs, operation codes, register indexes and lane sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package slr_pkg;

  // lane sizing
  localparam int MAX_LANES  = 4;
  localparam int NUM_FIELDS = 4;
  localparam int ACT_LANES  = (MAX_LANES < NUM_FIELDS) ? MAX_LANES : NUM_FIELDS;
  localparam int LANE_W     = 32;

  // configuration port sizing
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;
  localparam int OP_W       = 2;
  localparam int CNT_W      = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REDUCE_OP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LANE_COUNT = 2'd1;

  // reduction codes (unused code behaves as sum)
  localparam logic [OP_W-1:0] OP_MIN = 2'd0;
  localparam logic [OP_W-1:0] OP_MAX = 2'd1;
  localparam logic [OP_W-1:0] OP_SUM = 2'd2;

  // reset values of the registers
  localparam logic [OP_W-1:0]  REDUCE_OP_RST  = OP_SUM;
  localparam logic [CNT_W-1:0] LANE_COUNT_RST = 3'd1;

  // identities of the reductions
  localparam logic [LANE_W-1:0] ID_MIN = 32'h7FFF_FFFF;
  localparam logic [LANE_W-1:0] ID_MAX = 32'h8000_0000;
  localparam logic [LANE_W-1:0] ID_SUM = 32'h0000_0000;

  typedef logic signed [LANE_W-1:0] lane_t;

  // one input request
  typedef struct packed {
    lane_t lane_value_0;
    lane_t lane_value_1;
    lane_t lane_value_2;
    lane_t lane_value_3;
    logic  closes_segment;
    logic  carries_no_row;
  } slr_in_t;

  // one result request
  typedef struct packed {
    lane_t reduced_0;
    lane_t reduced_1;
    lane_t reduced_2;
    lane_t reduced_3;
  } slr_out_t;

  // step control from the input stage to the accumulators
  typedef struct packed {
    logic fire;
    logic closes;
    logic no_row;
  } slr_step_t;

endpackage

`default_nettype wire

@@ design/slr_in_reg.sv @@
// ----------------------------------------------------------------------------
// slr_in_reg - input register stage
// Holds one accepted request and releases it when the fold step can run.
// ----------------------------------------------------------------------------
`default_nettype none

module slr_in_reg
  import slr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire slr_in_t in_data,
  input  wire logic    out_free,
  output slr_step_t    step,
  output slr_in_t      s1_data
);

  logic    s1_valid_r, s1_valid_nxt;
  slr_in_t s1_data_r;
  logic    fire;
  logic    take;

  // a closing request needs room in the result register
  assign fire = s1_valid_r && (!s1_data_r.closes_segment || out_free);
  assign in_stall = s1_valid_r && !fire;
  assign take = in_valid && !in_stall;

  assign s1_valid_nxt = (s1_valid_r && !fire) || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (take) begin
      s1_data_r <= in_data;
    end
  end

  assign step.fire   = fire;
  assign step.closes = s1_data_r.closes_segment;
  assign step.no_row = s1_data_r.carries_no_row;
  assign s1_data     = s1_data_r;

endmodule

`default_nettype wire

@@ design/slr_accum.sv @@
// ----------------------------------------------------------------------------
// slr_accum - per-lane accumulators and fold logic
// Folds one row into the running min, max or sum and forms the segment result.
// ----------------------------------------------------------------------------
`default_nettype none

module slr_accum
  import slr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire slr_step_t        step,
  input  wire slr_in_t          s1_data,
  input  wire logic [OP_W-1:0]  reduce_op,
  input  wire logic [CNT_W-1:0] lane_count,
  output slr_out_t              result
);

  lane_t acc_r   [ACT_LANES];
  lane_t acc_nxt [ACT_LANES];
  lane_t acc_upd [ACT_LANES];
  lane_t lane_v  [NUM_FIELDS];
  lane_t res_v   [NUM_FIELDS];
  logic  lane_en [ACT_LANES];
  logic  started_r, started_nxt, started_upd;
  lane_t ident;

  // unpack the row into lanes
  always_comb begin
    lane_v[0] = s1_data.lane_value_0;
    lane_v[1] = s1_data.lane_value_1;
    lane_v[2] = s1_data.lane_value_2;
    lane_v[3] = s1_data.lane_value_3;
  end

  // identity for an empty segment
  always_comb begin
    case (reduce_op)
      OP_MIN:  ident = ID_MIN;
      OP_MAX:  ident = ID_MAX;
      default: ident = ID_SUM;
    endcase
  end

  assign started_upd = started_r || !step.no_row;

  // fold each enabled lane
  always_comb begin
    lane_t folded;
    folded = '0;
    for (int j = 0; j < ACT_LANES; j++) begin
      lane_en[j] = (lane_count > CNT_W'(j));
      case (reduce_op)
        OP_MIN:  folded = (lane_v[j] < acc_r[j]) ? lane_v[j] : acc_r[j];
        OP_MAX:  folded = (lane_v[j] > acc_r[j]) ? lane_v[j] : acc_r[j];
        default: folded = acc_r[j] + lane_v[j];
      endcase
      if (!step.no_row && lane_en[j]) begin
        acc_upd[j] = started_r ? folded : lane_v[j];
      end else begin
        acc_upd[j] = acc_r[j];
      end
    end
  end

  // result lanes, zero above the lane count
  always_comb begin
    for (int j = 0; j < NUM_FIELDS; j++) begin
      res_v[j] = '0;
    end
    for (int j = 0; j < ACT_LANES; j++) begin
      if (lane_en[j]) begin
        res_v[j] = started_upd ? acc_upd[j] : ident;
      end
    end
  end

  assign result.reduced_0 = res_v[0];
  assign result.reduced_1 = res_v[1];
  assign result.reduced_2 = res_v[2];
  assign result.reduced_3 = res_v[3];

  // next accumulator state, cleared on segment close
  always_comb begin
    started_nxt = started_r;
    for (int j = 0; j < ACT_LANES; j++) begin
      acc_nxt[j] = acc_r[j];
    end
    if (step.fire) begin
      if (step.closes) begin
        started_nxt = 1'b0;
        for (int j = 0; j < ACT_LANES; j++) begin
          acc_nxt[j] = '0;
        end
      end else begin
        started_nxt = started_upd;
        for (int j = 0; j < ACT_LANES; j++) begin
          acc_nxt[j] = acc_upd[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      for (int j = 0; j < ACT_LANES; j++) begin
        acc_r[j] <= '0;
      end
    end else begin
      started_r <= started_nxt;
      for (int j = 0; j < ACT_LANES; j++) begin
        acc_r[j] <= acc_nxt[j];
      end
    end
  end

endmodule

`default_nettype wire

@@ design/slr_out_reg.sv @@
// ----------------------------------------------------------------------------
// slr_out_reg - result register
// Holds one result request until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module slr_out_reg
  import slr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     load,
  input  wire slr_out_t result,
  output logic          out_free,
  output logic          out_valid,
  input  wire logic     out_stall,
  output slr_out_t      out_data
);

  logic     out_valid_r, out_valid_nxt;
  slr_out_t out_data_r;

  // free when empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid_nxt = (out_valid_r && out_stall) || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ design/segmented_lane_reduce.sv @@
// ----------------------------------------------------------------------------
// segmented_lane_reduce - segmented min / max / sum over four signed lanes
// Streams rows into per-lane accumulators and emits one row per segment.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests arrive on in_valid / in_data and are taken on a clock edge
//   with in_valid high and in_stall low. A request with closes_segment set
//   produces one result request on out_valid / out_data, taken when out_stall
//   is low; other requests only update the accumulators.
//   A closing request waits in the input register until the result register
//   has room, and is then folded into the result register, which raises
//   out_valid. Throughput: one request per cycle while in_stall is low; the
//   accumulator loop is a single compare-or-add per lane between the input
//   and result registers.
//   When the receiver stalls, the result register holds its request; requests
//   that do not close a segment keep flowing, and in_stall rises only while a
//   closing request waits in the input register behind a full result register.
//   Registers are written on cfg_valid with cfg_ready (always high); the user
//   must write only while no request is in flight; the block does not
//   enforce this. Reset (rst_n low, synchronous) empties both registers,
//   clears the accumulators and sets reduce_op to sum and lane_count to one.
// ----------------------------------------------------------------------------
`default_nettype none

module segmented_lane_reduce
  import slr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire slr_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output slr_out_t                   out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [OP_W-1:0]  reduce_op_r, reduce_op_nxt;
  logic [CNT_W-1:0] lane_count_r, lane_count_nxt;
  slr_step_t        step;
  slr_in_t          s1_data;
  slr_out_t         result;
  logic             out_free;

  assign cfg_ready = 1'b1;

  // register writes
  always_comb begin
    reduce_op_nxt  = reduce_op_r;
    lane_count_nxt = lane_count_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_REDUCE_OP:  reduce_op_nxt  = cfg_wdata[OP_W-1:0];
        CFG_LANE_COUNT: lane_count_nxt = cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reduce_op_r  <= REDUCE_OP_RST;
      lane_count_r <= LANE_COUNT_RST;
    end else begin
      reduce_op_r  <= reduce_op_nxt;
      lane_count_r <= lane_count_nxt;
    end
  end

  // input register
  slr_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_free (out_free),
    .step     (step),
    .s1_data  (s1_data)
  );

  // accumulators and fold
  slr_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .s1_data    (s1_data),
    .reduce_op  (reduce_op_r),
    .lane_count (lane_count_r),
    .result     (result)
  );

  // result register
  slr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step.fire && step.closes),
    .result    (result),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ design/slr_checker.sv @@
// ----------------------------------------------------------------------------
// slr_checker - port-level checks of the segmented lane reducer
// Watches the request channels over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module slr_checker
  import slr_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire slr_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire slr_out_t out_data
);

  // stalled result request holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result request changed");

  // reset leaves no result pending
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a closing request reaches the output once there is room after acceptance
  a_close_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.closes_segment) ##1 (!out_valid || !out_stall)
    |=> out_valid)
    else $error("closing request produced no result");

  // the input side is never held off while the output side is empty
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

endmodule

bind segmented_lane_reduce slr_checker u_slr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
